// ===== hdl/sdcs_pkg.sv =====
package sdcs_pkg;

  localparam int SectorBytes   = 512;
  localparam int ResponseDepth = 24;
  localparam int PosW          = 10;
  localparam logic [PosW-1:0] PosIdle = '1;

  typedef enum logic [2:0] {
    KIND_XCHG   = 3'd0,
    KIND_SELECT = 3'd1,
    KIND_FILL   = 3'd2,
    KIND_READ   = 3'd3,
    KIND_DONE   = 3'd4
  } kind_e;

  localparam logic [7:0] CmdGoIdle   = 8'h40;
  localparam logic [7:0] CmdSendOp   = 8'h41;
  localparam logic [7:0] CmdIfCond   = 8'h48;
  localparam logic [7:0] CmdSendCsd  = 8'h49;
  localparam logic [7:0] CmdSendCid  = 8'h4A;
  localparam logic [7:0] CmdStop     = 8'h4C;
  localparam logic [7:0] CmdBlockLen = 8'h50;
  localparam logic [7:0] CmdRead1    = 8'h51;
  localparam logic [7:0] CmdReadN    = 8'h52;
  localparam logic [7:0] CmdWrite1   = 8'h58;
  localparam logic [7:0] CmdWriteN   = 8'h59;
  localparam logic [7:0] CmdAppCmd   = 8'h77;
  localparam logic [7:0] CmdReadOcr  = 8'h7A;
  localparam logic [7:0] CmdCrcOn    = 8'h7B;
  localparam logic [7:0] CmdAppOp    = 8'h69;

  localparam logic [7:0] TokStart    = 8'hFE;
  localparam logic [7:0] TokMulti    = 8'hFC;
  localparam logic [7:0] TokStop     = 8'hFD;
  localparam logic [7:0] TokAccept   = 8'h05;
  localparam logic [7:0] TokDataErr  = 8'h08;
  localparam logic [7:0] R1Illegal   = 8'h04;
  localparam logic [7:0] R1AddrErr   = 8'h40;

  typedef struct packed {
    logic [7:0]  miso_byte;
    logic [7:0]  buffer_byte;
    logic        request_post;
    logic        request_write;
    logic [31:0] request_sector;
  } result_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] mosi_byte;
    logic       select_level;
    logic [8:0] buffer_index;
    logic [7:0] buffer_data;
    logic       backend_ok;
  } item_t;

  function automatic logic [7:0] cid_byte(input logic [3:0] i);
    logic [7:0] b;
    unique case (i)
      4'd0: b = 8'h01;  4'd1: b = 8'h50;  4'd2: b = 8'h49;  4'd3: b = 8'h43;
      4'd4: b = 8'h4F;  4'd5: b = 8'h53;  4'd6: b = 8'h50;  4'd7: b = 8'h43;
      4'd8: b = 8'h4E;  4'd9: b = 8'h47;  4'd10: b = 8'h53; 4'd11: b = 8'h10;
      4'd12: b = 8'h00; 4'd13: b = 8'h00; 4'd14: b = 8'h01; default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] csd_byte(input logic [3:0] i, input logic [21:0] c);
    logic [7:0] b;
    unique case (i)
      4'd0: b = 8'h40;  4'd1: b = 8'h0E;  4'd3: b = 8'h32;  4'd4: b = 8'h5B;
      4'd5: b = 8'h59;  4'd7: b = {2'b00, c[21:16]};
      4'd8: b = c[15:8]; 4'd9: b = c[7:0];
      4'd10: b = 8'h7F; 4'd11: b = 8'h80; 4'd12: b = 8'h0A; 4'd13: b = 8'h40;
      4'd15: b = 8'h01; default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== hdl/sdcs_stream_if.sv =====
interface sdcs_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/sdcs_sector_ram.sv =====
module sdcs_sector_ram #(
  parameter int Depth = sdcs_pkg::SectorBytes
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [7:0]               wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [7:0]               rdata_o
);
  logic [7:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end
endmodule

// ===== hdl/sd_card_spi_slave.sv =====
// An accepted request is registered while the sector buffer memory is read; the
// card state is then updated and the result registered. A new request is taken
// only when none is in process and the output holds no result that waits.
// Reset: asynchronous, active low; card deselected and idle, no streams,
// capacity zero. The sector buffer is not cleared.
module sd_card_spi_slave #(
  parameter int SectorBytes   = sdcs_pkg::SectorBytes,
  parameter int ResponseDepth = sdcs_pkg::ResponseDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  sdcs_stream_if.sink   in_i,
  sdcs_stream_if.source out_o
);
  import sdcs_pkg::*;

  localparam int AW = $clog2(SectorBytes);
  localparam int RW = $clog2(ResponseDepth + 1);
  localparam logic [PosW-1:0] PosLast = PosW'(SectorBytes);

  logic [31:0] sectors_q;
  logic        selected_q, idle_q;
  logic [7:0]  frame_q [5];
  logic [2:0]  fcount_q;
  logic [7:0]  resp_q [ResponseDepth];
  logic [RW-1:0] rlen_q, rpos_q;
  logic [PosW-1:0] rdpos_q, wrpos_q;
  logic        rzero_q, rmulti_q, wmulti_q, wbusy_q, pend_q, ok_q;
  logic [31:0] rsec_q, wsec_q;

  logic [7:0]  frame_d [5];
  logic [2:0]  fcount_d;
  logic [7:0]  resp_d [ResponseDepth];
  logic [RW-1:0] rlen_d, rpos_d;
  logic [PosW-1:0] rdpos_d, wrpos_d;
  logic        selected_d, idle_d, rzero_d, rmulti_d, wmulti_d, wbusy_d, pend_d, ok_d;
  logic [31:0] rsec_d, wsec_d;

  logic        busy_q;
  item_t       item_q;
  logic        out_valid_q;
  result_t     out_q, res;

  logic        ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]  ram_wdata, ram_rdata;

  logic        take, stage2;

  assign stage2   = busy_q;
  assign in_i.ready = !busy_q && (!out_valid_q || out_o.ready);
  assign take     = in_i.valid && in_i.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  always_comb begin
    if (in_i.data.kind == KIND_READ) begin
      ram_raddr = in_i.data.buffer_index;
    end else begin
      ram_raddr = AW'(rdpos_q - PosW'(1));
    end
  end

  sdcs_sector_ram #(.Depth(SectorBytes)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    logic [7:0]  v, cmd, miso;
    logic [31:0] arg, c32;
    logic [21:0] csz;
    selected_d = selected_q; idle_d = idle_q; frame_d = frame_q; fcount_d = fcount_q;
    resp_d = resp_q; rlen_d = rlen_q; rpos_d = rpos_q; rdpos_d = rdpos_q;
    wrpos_d = wrpos_q; rzero_d = rzero_q; rmulti_d = rmulti_q; wmulti_d = wmulti_q;
    wbusy_d = wbusy_q; pend_d = pend_q; ok_d = ok_q; rsec_d = rsec_q; wsec_d = wsec_q;
    res = '0; res.miso_byte = 8'hFF;
    ram_we = 1'b0; ram_waddr = item_q.buffer_index; ram_wdata = item_q.buffer_data;
    v = item_q.mosi_byte; miso = 8'hFF;
    cmd = frame_q[0];
    arg = {frame_q[1], frame_q[2], frame_q[3], frame_q[4]};
    c32 = {10'd0, sectors_q[31:10]};
    if (c32 != 0) c32 = c32 - 32'd1;
    csz = c32[21:0];
    if (stage2) begin
      unique case (item_q.kind)
        KIND_XCHG: begin
          if (selected_q && sectors_q != 0) begin
            if (rpos_q < rlen_q) begin
              miso = resp_q[rpos_q[$clog2(ResponseDepth)-1:0]];
              rpos_d = rpos_q + RW'(1);
            end else if (rdpos_q != PosIdle) begin
              if (rdpos_q == 0) begin
                if (!rzero_q && pend_q) begin
                  miso = 8'hFF;
                end else if (!rzero_q && !ok_q) begin
                  rdpos_d = PosIdle; miso = TokDataErr;
                end else begin
                  rdpos_d = PosW'(1); miso = TokStart;
                end
              end else if (rdpos_q <= PosLast) begin
                rdpos_d = rdpos_q + PosW'(1);
                miso = rzero_q ? 8'h00 : ram_rdata;
              end else if (rdpos_q <= PosLast + PosW'(2)) begin
                rdpos_d = rdpos_q + PosW'(1);
              end else if (rmulti_q) begin
                rsec_d = rsec_q + 32'd1;
                rdpos_d = '0;
                if (!rzero_q) begin
                  res.request_post = 1'b1; res.request_write = 1'b0;
                  res.request_sector = rsec_q + 32'd1; pend_d = 1'b1;
                end
              end else begin
                rdpos_d = PosIdle;
              end
            end else if (wbusy_q) begin
              if (pend_q) miso = 8'h00;
              else wbusy_d = 1'b0;
            end
            res.miso_byte = miso;
            if (wrpos_q != PosIdle) begin
              if (wrpos_q == 0) begin
                if (v == TokStart || (wmulti_q && v == TokMulti)) begin
                  wrpos_d = PosW'(1);
                end else if (wmulti_q && v == TokStop) begin
                  wmulti_d = 1'b0; wrpos_d = PosIdle;
                end
              end else if (wrpos_q <= PosLast) begin
                ram_we = 1'b1; ram_waddr = AW'(wrpos_q - PosW'(1)); ram_wdata = v;
                wrpos_d = wrpos_q + PosW'(1);
              end else begin
                wrpos_d = wrpos_q + PosW'(1);
                if (wrpos_d >= PosLast + PosW'(3)) begin
                  resp_d[0] = TokAccept; rlen_d = RW'(1); rpos_d = '0;
                  wbusy_d = 1'b1; pend_d = 1'b1;
                  res.request_post = 1'b1; res.request_write = 1'b1;
                  res.request_sector = wsec_q;
                  if (wmulti_q) begin
                    wsec_d = wsec_q + 32'd1; wrpos_d = '0;
                  end else begin
                    wrpos_d = PosIdle;
                  end
                end
              end
            end else if (fcount_q == 0) begin
              if (v[7:6] == 2'b01) begin
                frame_d[0] = v; fcount_d = 3'd1;
              end
            end else if (fcount_q < 3'd5) begin
              frame_d[fcount_q] = v; fcount_d = fcount_q + 3'd1;
            end else begin
              fcount_d = '0;
              rpos_d = '0; rlen_d = RW'(2);
              resp_d[0] = 8'hFF;
              unique case (cmd)
                CmdGoIdle: begin
                  rdpos_d = PosIdle; rzero_d = 1'b0; rmulti_d = 1'b0;
                  wrpos_d = PosIdle; wmulti_d = 1'b0; wbusy_d = 1'b0;
                  idle_d = 1'b1; resp_d[1] = 8'h01;
                end
                CmdSendOp, CmdAppOp: begin
                  idle_d = 1'b0; resp_d[1] = 8'h00;
                end
                CmdIfCond: begin
                  resp_d[1] = 8'h01;
                  resp_d[2] = frame_q[1]; resp_d[3] = frame_q[2];
                  resp_d[4] = frame_q[3]; resp_d[5] = frame_q[4];
                  rlen_d = RW'(6);
                end
                CmdSendCsd, CmdSendCid: begin
                  resp_d[1] = 8'h00; resp_d[2] = TokStart;
                  for (int i = 0; i < 16; i++) begin
                    resp_d[3+i] = (cmd == CmdSendCsd) ? csd_byte(4'(i), csz)
                                                      : cid_byte(4'(i));
                  end
                  resp_d[19] = 8'hFF; resp_d[20] = 8'hFF;
                  rlen_d = RW'(21);
                end
                CmdStop: begin
                  rdpos_d = PosIdle; rmulti_d = 1'b0; rzero_d = 1'b0;
                  resp_d[1] = 8'hFF; resp_d[2] = 8'h00; rlen_d = RW'(3);
                end
                CmdBlockLen, CmdCrcOn: resp_d[1] = 8'h00;
                CmdRead1, CmdReadN: begin
                  resp_d[1] = 8'h00;
                  rsec_d = arg; rdpos_d = '0; rmulti_d = (cmd == CmdReadN);
                  rzero_d = (arg >= sectors_q);
                  if (arg < sectors_q) begin
                    res.request_post = 1'b1; res.request_write = 1'b0;
                    res.request_sector = arg; pend_d = 1'b1;
                  end
                end
                CmdWrite1, CmdWriteN: begin
                  if (arg >= sectors_q) begin
                    resp_d[1] = R1AddrErr;
                  end else begin
                    resp_d[1] = 8'h00; wsec_d = arg;
                    wmulti_d = (cmd == CmdWriteN); wrpos_d = '0;
                  end
                end
                CmdAppCmd: resp_d[1] = idle_q ? 8'h01 : 8'h00;
                CmdReadOcr: begin
                  resp_d[1] = 8'h00; resp_d[2] = 8'hC0; resp_d[3] = 8'hFF;
                  resp_d[4] = 8'h80; resp_d[5] = 8'h00; rlen_d = RW'(6);
                end
                default: resp_d[1] = R1Illegal;
              endcase
            end
          end
        end
        KIND_SELECT: begin
          if (item_q.select_level != selected_q) begin
            selected_d = item_q.select_level;
            fcount_d = '0; rlen_d = '0; rpos_d = '0;
            if (!item_q.select_level) begin
              rdpos_d = PosIdle; rzero_d = 1'b0; rmulti_d = 1'b0;
              wrpos_d = PosIdle; wmulti_d = 1'b0;
            end
          end
        end
        KIND_FILL: ram_we = 1'b1;
        KIND_READ: res.buffer_byte = ram_rdata;
        KIND_DONE: begin
          if (pend_q) begin
            ok_d = item_q.backend_ok; pend_d = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sectors_q <= '0; selected_q <= 1'b0; idle_q <= 1'b1; fcount_q <= '0;
      rlen_q <= '0; rpos_q <= '0; rdpos_q <= PosIdle; wrpos_q <= PosIdle;
      rzero_q <= 1'b0; rmulti_q <= 1'b0; wmulti_q <= 1'b0; wbusy_q <= 1'b0;
      pend_q <= 1'b0; ok_q <= 1'b0; rsec_q <= '0; wsec_q <= '0;
      busy_q <= 1'b0; out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) sectors_q <= cfg_wdata_i;
      busy_q <= take;
      if (stage2) begin
        out_valid_q <= 1'b1;
        selected_q <= selected_d; idle_q <= idle_d; fcount_q <= fcount_d;
        rlen_q <= rlen_d; rpos_q <= rpos_d; rdpos_q <= rdpos_d; wrpos_q <= wrpos_d;
        rzero_q <= rzero_d; rmulti_q <= rmulti_d; wmulti_q <= wmulti_d;
        wbusy_q <= wbusy_d; pend_q <= pend_d; ok_q <= ok_d;
        rsec_q <= rsec_d; wsec_q <= wsec_d;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) item_q <= in_i.data;
    if (stage2) begin
      out_q <= res; frame_q <= frame_d; resp_q <= resp_d;
    end
  end
endmodule

// ===== test/tb_sd_card_spi_slave.sv =====
`timescale 1ns / 100ps

module tb_sd_card_spi_slave;
  import sdcs_pkg::*;

  localparam logic [9:0] PosNone = 10'h3FF;

  class card_scoreboard;
    logic [31:0] sectors;
    bit          selected, idle_flag;
    logic [7:0]  frame [5];
    int          frame_count;
    logic [7:0]  resp [ResponseDepth];
    int          resp_len, resp_pos;
    logic [9:0]  rd_pos;
    bit          rd_zero, rd_multi;
    logic [31:0] rd_sector;
    logic [9:0]  wr_pos;
    logic [31:0] wr_sector;
    bit          wr_multi, wr_busy, req_pending, req_ok;
    logic [7:0]  sbuf [SectorBytes];
    result_t     expected_q[$];
    result_t     cur;
    int          errors, results, posts, reads_done, writes_done;

    function new();
      sectors = 0; selected = 0; idle_flag = 1; frame_count = 0;
      resp_len = 0; resp_pos = 0; rd_pos = PosNone; rd_zero = 0; rd_multi = 0;
      rd_sector = 0; wr_pos = PosNone; wr_sector = 0; wr_multi = 0; wr_busy = 0;
      req_pending = 0; req_ok = 0; errors = 0; results = 0;
      posts = 0; reads_done = 0; writes_done = 0;
      foreach (sbuf[i]) sbuf[i] = 8'h00;
    endfunction

    function void load_resp(logic [7:0] d[], int n);
      for (int i = 0; i < n; i++) resp[i] = d[i];
      resp_len = n; resp_pos = 0;
    endfunction

    function void post(bit wr, logic [31:0] sec);
      cur.request_post = 1; cur.request_write = wr; cur.request_sector = sec;
      req_pending = 1; posts++;
    endfunction

    function void end_streams();
      rd_pos = PosNone; rd_zero = 0; rd_multi = 0; wr_pos = PosNone; wr_multi = 0;
    endfunction

    function void reg_resp(logic [7:0] r[16]);
      logic [7:0] d[];
      d = new[21];
      d[0] = 8'hFF; d[1] = 8'h00; d[2] = TokStart;
      for (int i = 0; i < 16; i++) d[3+i] = r[i];
      d[19] = 8'hFF; d[20] = 8'hFF;
      load_resp(d, 21);
    endfunction

    function void run_command();
      logic [7:0]  cmd;
      logic [31:0] arg, c;
      logic [7:0]  r[], rg[16];
      cmd = frame[0];
      arg = {frame[1], frame[2], frame[3], frame[4]};
      r = new[2];
      r[0] = 8'hFF;
      case (cmd)
        CmdGoIdle: begin
          end_streams(); wr_busy = 0; idle_flag = 1; r[1] = 8'h01; load_resp(r, 2);
        end
        CmdSendOp, CmdAppOp: begin
          idle_flag = 0; r[1] = 8'h00; load_resp(r, 2);
        end
        CmdIfCond: begin
          r = new[6];
          r[0] = 8'hFF; r[1] = 8'h01;
          for (int i = 0; i < 4; i++) r[2+i] = frame[1+i];
          load_resp(r, 6);
        end
        CmdSendCsd: begin
          c = sectors / 1024;
          if (c != 0) c = c - 1;
          foreach (rg[i]) rg[i] = 8'h00;
          rg[0] = 8'h40; rg[1] = 8'h0E; rg[3] = 8'h32; rg[4] = 8'h5B; rg[5] = 8'h59;
          rg[7] = {2'b00, c[21:16]}; rg[8] = c[15:8]; rg[9] = c[7:0];
          rg[10] = 8'h7F; rg[11] = 8'h80; rg[12] = 8'h0A; rg[13] = 8'h40; rg[15] = 8'h01;
          reg_resp(rg);
        end
        CmdSendCid: begin
          rg = '{8'h01, 8'h50, 8'h49, 8'h43, 8'h4F, 8'h53, 8'h50, 8'h43,
                 8'h4E, 8'h47, 8'h53, 8'h10, 8'h00, 8'h00, 8'h01, 8'h00};
          reg_resp(rg);
        end
        CmdStop: begin
          rd_pos = PosNone; rd_multi = 0; rd_zero = 0;
          r = new[3];
          r[0] = 8'hFF; r[1] = 8'hFF; r[2] = 8'h00; load_resp(r, 3);
        end
        CmdBlockLen, CmdCrcOn: begin
          r[1] = 8'h00; load_resp(r, 2);
        end
        CmdRead1, CmdReadN: begin
          r[1] = 8'h00; load_resp(r, 2);
          rd_sector = arg; rd_pos = 0; rd_multi = (cmd == CmdReadN);
          rd_zero = (arg >= sectors);
          if (!rd_zero) post(0, arg);
        end
        CmdWrite1, CmdWriteN: begin
          if (arg >= sectors) begin
            r[1] = R1AddrErr; load_resp(r, 2);
          end else begin
            r[1] = 8'h00; load_resp(r, 2);
            wr_sector = arg; wr_multi = (cmd == CmdWriteN); wr_pos = 0;
          end
        end
        CmdAppCmd: begin
          r[1] = idle_flag ? 8'h01 : 8'h00; load_resp(r, 2);
        end
        CmdReadOcr: begin
          r = new[6];
          r = '{8'hFF, 8'h00, 8'hC0, 8'hFF, 8'h80, 8'h00};
          load_resp(r, 6);
        end
        default: begin
          r[1] = R1Illegal; load_resp(r, 2);
        end
      endcase
    endfunction

    function logic [7:0] card_out();
      if (resp_pos < resp_len) begin
        resp_pos++;
        return resp[resp_pos-1];
      end
      if (rd_pos != PosNone) begin
        if (rd_pos == 0) begin
          if (!rd_zero) begin
            if (req_pending) return 8'hFF;
            if (!req_ok) begin
              rd_pos = PosNone; return TokDataErr;
            end
          end
          rd_pos = 1;
          return TokStart;
        end
        if (rd_pos <= SectorBytes) begin
          rd_pos++;
          return rd_zero ? 8'h00 : sbuf[rd_pos-2];
        end
        if (rd_pos <= SectorBytes + 2) begin
          rd_pos++; return 8'hFF;
        end
        reads_done++;
        if (rd_multi) begin
          rd_sector++; rd_pos = 0;
          if (!rd_zero) post(0, rd_sector);
        end else rd_pos = PosNone;
        return 8'hFF;
      end
      if (wr_busy) begin
        if (req_pending) return 8'h00;
        wr_busy = 0;
      end
      return 8'hFF;
    endfunction

    function void card_in(logic [7:0] v);
      logic [7:0] a[];
      if (wr_pos != PosNone) begin
        if (wr_pos == 0) begin
          if (v == TokStart || (wr_multi && v == TokMulti)) wr_pos = 1;
          else if (wr_multi && v == TokStop) begin
            wr_multi = 0; wr_pos = PosNone;
          end
          return;
        end
        if (wr_pos <= SectorBytes) begin
          sbuf[wr_pos-1] = v; wr_pos++; return;
        end
        wr_pos++;
        if (wr_pos >= SectorBytes + 3) begin
          a = new[1]; a[0] = TokAccept; load_resp(a, 1);
          wr_busy = 1; post(1, wr_sector); writes_done++;
          if (wr_multi) begin
            wr_sector++; wr_pos = 0;
          end else wr_pos = PosNone;
        end
        return;
      end
      if (frame_count == 0) begin
        if ((v & 8'hC0) != 8'h40) return;
        frame[0] = v; frame_count = 1; return;
      end
      if (frame_count < 5) begin
        frame[frame_count] = v; frame_count++; return;
      end
      frame_count = 0;
      run_command();
    endfunction

    function void note_request(item_t it);
      cur = '0;
      cur.miso_byte = 8'hFF;
      case (it.kind)
        KIND_XCHG: if (selected && sectors != 0) begin
          cur.miso_byte = card_out();
          card_in(it.mosi_byte);
        end
        KIND_SELECT: if (it.select_level != selected) begin
          selected = it.select_level; frame_count = 0; resp_len = 0; resp_pos = 0;
          if (!it.select_level) end_streams();
        end
        KIND_FILL: sbuf[it.buffer_index] = it.buffer_data;
        KIND_READ: cur.buffer_byte = sbuf[it.buffer_index];
        KIND_DONE: if (req_pending) begin
          req_ok = it.backend_ok; req_pending = 0;
        end
        default: ;
      endcase
      expected_q.push_back(cur);
    endfunction

    function void check_result(result_t got);
      result_t e;
      results++;
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result %h", $time, got);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (got.miso_byte !== e.miso_byte)
        $display("%0t miso_byte exp %h got %h", $time, e.miso_byte, got.miso_byte);
      if (got.buffer_byte !== e.buffer_byte)
        $display("%0t buffer_byte exp %h got %h", $time, e.buffer_byte, got.buffer_byte);
      if (got.request_post !== e.request_post)
        $display("%0t request_post exp %b got %b", $time, e.request_post,
                 got.request_post);
      if (got.request_write !== e.request_write)
        $display("%0t request_write exp %b got %b", $time, e.request_write,
                 got.request_write);
      if (got.request_sector !== e.request_sector)
        $display("%0t request_sector exp %h got %h", $time, e.request_sector,
                 got.request_sector);
      if (got !== e) errors++;
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic [31:0] cfg_wdata_i = '0;
  int          hold_cycles = 0;
  int          sent = 0;
  bit          rx_random = 1;

  sdcs_stream_if #(.T(item_t))   req_if ();
  sdcs_stream_if #(.T(result_t)) res_if ();

  card_scoreboard sb = new();

  sd_card_spi_slave DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_i(req_if.sink), .out_o(res_if.source)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    req_if.valid = 0;
    req_if.data = '0;
    res_if.ready = 0;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) sb.check_result(res_if.data);
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      res_if.ready <= 0;
    end else if (!rx_random) begin
      res_if.ready <= 1;
    end else begin
      res_if.ready <= (gap_len() == 0);
    end
  end

  task automatic send(item_t it);
    int g;
    g = gap_len();
    if (g > 0) begin
      req_if.valid <= 0;
      repeat (g) @(posedge clk_i);
    end
    req_if.data <= it;
    req_if.valid <= 1;
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_request(it);
    sent++;
  endtask

  task automatic xchg(logic [7:0] b);
    item_t it;
    it = '0;
    it.kind = KIND_XCHG; it.mosi_byte = b;
    it.select_level = 1'($urandom); it.buffer_index = 9'($urandom);
    it.buffer_data = 8'($urandom);
    it.backend_ok = 1'($urandom);
    send(it);
  endtask

  task automatic chip_select(bit lvl);
    item_t it;
    it = '0;
    it.kind = KIND_SELECT; it.select_level = lvl; it.mosi_byte = 8'($urandom);
    send(it);
  endtask

  task automatic fill(logic [8:0] idx, logic [7:0] d);
    item_t it;
    it = '0;
    it.kind = KIND_FILL; it.buffer_index = idx; it.buffer_data = d;
    send(it);
  endtask

  task automatic peek(logic [8:0] idx);
    item_t it;
    it = '0;
    it.kind = KIND_READ; it.buffer_index = idx;
    send(it);
  endtask

  task automatic backend_done(bit ok);
    item_t it;
    it = '0;
    it.kind = KIND_DONE; it.backend_ok = ok;
    send(it);
  endtask

  task automatic command(logic [7:0] cmd, logic [31:0] arg);
    xchg(cmd); xchg(arg[31:24]); xchg(arg[23:16]); xchg(arg[15:8]); xchg(arg[7:0]);
    xchg(8'($urandom));
  endtask

  task automatic drain();
    req_if.valid <= 0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic set_sectors(logic [31:0] v);
    drain();
    cfg_we_i <= 1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 0;
    sb.sectors = v;
  endtask

  task automatic clock_out(int n);
    repeat (n) xchg(8'hFF);
  endtask

  task automatic send_block(logic [7:0] tok);
    xchg(tok);
    repeat (SectorBytes) xchg(8'($urandom));
    xchg(8'($urandom)); xchg(8'($urandom));
  endtask

  task automatic random_session();
    int op;
    logic [31:0] sec;
    op = $urandom_range(0, 11);
    sec = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, sb.sectors + 2);
    case (op)
      0: command(CmdGoIdle, $urandom);
      1: command(CmdSendOp, $urandom);
      2: command(CmdIfCond, $urandom);
      3: command($urandom_range(0, 1) ? CmdSendCsd : CmdSendCid, $urandom);
      4: command($urandom_range(0, 1) ? CmdAppCmd : CmdAppOp, $urandom);
      5: command($urandom_range(0, 1) ? CmdReadOcr : CmdCrcOn, $urandom);
      6: begin
        command($urandom_range(0, 1) ? CmdRead1 : CmdReadN, sec);
        clock_out($urandom_range(2, 6));
        if ($urandom_range(0, 1)) backend_done($urandom_range(0, 3) != 0);
        clock_out($urandom_range(3, 40));
        command(CmdStop, $urandom);
      end
      7: begin
        command($urandom_range(0, 1) ? CmdWrite1 : CmdWriteN, sec);
        clock_out(2);
        xchg(TokStop);
        clock_out(3);
        backend_done(1'($urandom));
        clock_out(2);
      end
      8: chip_select(1'($urandom));
      9: if ($urandom_range(0, 1)) fill(9'($urandom), 8'($urandom));
         else peek(9'($urandom));
      10: backend_done(1'($urandom));
      default: repeat ($urandom_range(1, 6)) xchg(8'($urandom));
    endcase
  endtask

  initial begin
    item_t it;
    for (int i = 0; i < SectorBytes; i++) sb.sbuf[i] = 8'h00;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    set_sectors(32'd4096);
    xchg(8'h40);
    chip_select(1);
    chip_select(1);
    command(CmdGoIdle, 0);  clock_out(2);
    command(CmdIfCond, 32'h000001AA); clock_out(6);
    command(CmdAppCmd, 0);  clock_out(2);
    command(CmdAppOp, 32'h40000000); clock_out(2);
    command(8'h7F, 0);      clock_out(2);
    command(CmdSendCsd, 0); clock_out(21);
    command(CmdReadOcr, 0); clock_out(6);
    command(CmdWriteN, 32'd7); clock_out(2);
    send_block(TokMulti); clock_out(2);
    backend_done(1);
    xchg(TokStop); clock_out(2);
    backend_done(1);
    backend_done(1);
    command(CmdRead1, 32'd5); clock_out(3);
    backend_done(1);
    clock_out(520);
    command(CmdReadN, 32'd4095); clock_out(4);
    backend_done(0); clock_out(3);
    command(CmdReadN, 32'hFFFF_FFFF); clock_out(24);
    command(CmdStop, 0); clock_out(3);
    command(CmdWrite1, 32'd4096); clock_out(3);
    peek(9'd0); peek(9'd511);
    it = '1; send(it);
    chip_select(0);
    xchg(8'h40);
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_sectors(32'd0);
        1: set_sectors(32'hFFFF_FFFF);
        2: set_sectors(32'd1);
        3: set_sectors(32'd1024);
        default: set_sectors($urandom_range(2, 5000));
      endcase
      chip_select(1);
      if (ph == 2) begin
        fork
          begin
            hold_cycles <= 400;
            @(posedge clk_i);
          end
        join
      end
      for (int k = 0; k < 3; k++) random_session();
      if (ph == 3) drain();
      chip_select(0);
    end
    rx_random = 0;
    drain();
    $display("Sent %0d requests, %0d results, %0d backend posts, %0d reads, %0d writes",
             sent, sb.results, sb.posts, sb.reads_done, sb.writes_done);
    $display("Capacities zero, one sector, 1024, max and random were covered");
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
